### rtl/ors_pkg.sv
// Shared types and constants for the in-order release reorder buffer.
package ors_pkg;

    // Field widths of the stream beats and the size register.
    localparam int ID_W        = 6;
    localparam int WORD_W      = 64;
    localparam int CFG_W       = 6;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 64;

    // Release limit per accepted beat and the width of its counter.
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_SEND
    } ors_state_t;

endpackage

### rtl/ors_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ors_ram
    #(
        parameter int WIDTH = 64,
        parameter int DEPTH = 32
    )
    (
        input  logic                                      aclk,
        input  logic                                      we,
        input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
        input  logic [WIDTH-1:0]                          wdata,
        input  logic                                      re,
        input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
        output logic [WIDTH-1:0]                          rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ordered_stream_release.sv
// Reorder buffer that stores words by slot id and releases them in id order.
//
//  Channel  | Direction | Payload
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | tdata: slot_id [5:0], data_word [69:6], zero pad
//  m_       | out       | tdata: out_word; tlast: last_of_run; tuser: bad_id
//  cfg_     | in        | data: stream_size (write clears slots, head to 1)
//
// A beat with a bad slot id is accepted, then answered with the error beat.
// A good beat is accepted, then the head is checked; each released slot is read
// from the slot RAM, then presented in the output register.
// Slots go one at a time through the single RAM read port and the head compare.
// Reset clears the filled bits and sets the head to 1 at once; there is no clearing pass.
// A stalled m_ beat holds the sequencer; no new beat is taken until the run ends.
module ordered_stream_release
    import ors_pkg::*;
    #(
        parameter int SLOTS = 32
    )
    (
        input  logic                 aclk,
        input  logic                 aresetn,
        // Input stream: slot_id [5:0], data_word [69:6], zeros above.
        input  logic                 s_tvalid,
        output logic                 s_tready,
        input  logic [S_TDATA_W-1:0] s_tdata,
        // Result stream: out_word [63:0].
        output logic                 m_tvalid,
        input  logic                 m_tready,
        output logic [M_TDATA_W-1:0] m_tdata,
        output logic                 m_tlast,
        // bad_id [0].
        output logic [0:0]           m_tuser,
        // Size register write channel.
        input  logic                 cfg_valid,
        output logic                 cfg_ready,
        input  logic [CFG_W-1:0]     cfg_data
    );

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = $clog2(SLOTS + 2);
    localparam int EW = (HW > ID_W) ? HW : ID_W;
    localparam logic [HW-1:0] SIZE_MAX = HW'(SLOTS);
    localparam logic [HW-1:0] HEAD_ONE = HW'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

    ors_state_t state_reg, state_next;

    logic [SLOTS-1:0]  filled_reg, filled_next;
    logic [HW-1:0]     head_reg, head_next;
    logic [HW-1:0]     size_reg, size_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic              out_last_reg, out_last_next;
    logic              out_bad_reg, out_bad_next;

    logic [ID_W-1:0]   in_id;
    logic [WORD_W-1:0] in_word;
    logic [ID_W-1:0]   id_m1;
    logic              id_ok;
    logic              s_hs, m_hs, cfg_hs;
    logic [HW-1:0]     head_sel;
    logic              head_rel;
    logic              more;
    logic              ram_we, ram_re;
    logic [WORD_W-1:0] ram_rdata;

    // Unpack the input beat and check the slot id against the size.
    assign in_id   = s_tdata[ID_W-1:0];
    assign in_word = s_tdata[ID_W+WORD_W-1:ID_W];
    assign id_m1   = in_id - ID_W'(1);
    assign id_ok   = (in_id != '0) && (EW'(in_id) <= EW'(size_reg));

    assign s_hs   = s_tvalid && s_tready;
    assign m_hs   = m_tvalid && m_tready;
    assign cfg_hs = cfg_valid && cfg_ready;

    // Shared head compare: is the slot under the head ready for release?
    assign head_sel = head_reg - HEAD_ONE;
    assign head_rel = (head_reg <= size_reg) ? filled_reg[head_sel[AW-1:0]] : 1'b0;
    assign more     = (count_reg < CNT_MAX) && head_rel;

    // Slot data store.
    ors_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (id_m1[AW-1:0]),
        .wdata (in_word),
        .re    (ram_re),
        .raddr (head_sel[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    state_next = id_ok ? ST_CHECK : ST_SEND;
                end
            end
            ST_CHECK: begin
                state_next = head_rel ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_hs) begin
                    state_next = out_last_reg ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and RAM strobes from the state.
    always_comb begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        m_tvalid  = 1'b0;
        ram_re    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
            end
            ST_CHECK: begin
                ram_re = head_rel;
            end
            ST_READ: begin
                ram_re = 1'b0;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                ram_re   = m_hs && !out_last_reg;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign ram_we = s_hs && id_ok;

    // Datapath next values: slot marks, head, size, run count and output register.
    always_comb begin
        filled_next   = filled_reg;
        head_next     = head_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        out_bad_next  = out_bad_reg;

        if (cfg_hs) begin
            if (cfg_data == '0) begin
                size_next = HEAD_ONE;
            end else if (EW'(cfg_data) > EW'(SIZE_MAX)) begin
                size_next = SIZE_MAX;
            end else begin
                size_next = HW'(cfg_data);
            end
            filled_next = '0;
            head_next   = HEAD_ONE;
        end

        if (s_hs) begin
            count_next = '0;
            if (id_ok) begin
                filled_next[id_m1[AW-1:0]] = 1'b1;
            end else begin
                out_word_next = '0;
                out_last_next = 1'b1;
                out_bad_next  = 1'b1;
            end
        end

        // Each RAM read releases the head slot.
        if (ram_re) begin
            head_next  = head_reg + HEAD_ONE;
            count_next = count_reg + CNT_W'(1);
        end

        // Read data lands; mark last unless the next slot can follow.
        if (state_reg == ST_READ) begin
            out_word_next = ram_rdata;
            out_last_next = !more;
            out_bad_next  = 1'b0;
        end
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            filled_reg <= '0;
            head_reg   <= HEAD_ONE;
            size_reg   <= SIZE_MAX;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            head_reg   <= head_next;
            size_reg   <= size_next;
            count_reg  <= count_next;
        end
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_tdata    = out_word_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_bad_reg;

`ifndef ASSERT_OFF
    // The head never runs more than one slot past the configured size.
    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(head_reg) <= EW'(size_reg) + EW'(1))
        else $error("head moved beyond size plus one");

    // An error beat is always a single, last beat with a zero word.
    a_bad_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
        else $error("error beat not marked last or word not zero");

    // No new input beat is taken while a result beat is pending.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // A size write clears every slot mark and resets the head.
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> ((filled_reg == '0) && (head_reg == HEAD_ONE)))
        else $error("size write did not clear slots");
`endif

endmodule
